@@ src/dlpg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlpg_pkg
// shared types and constants of the dda line point generator
// ----------------------------------------------------------------------------
package dlpg_pkg;

  // output point format
  localparam int unsigned OUT_W    = 14;
  localparam int unsigned OUT_FRAC = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV_X,
    ST_LOAD_Y,
    ST_DIV_Y,
    ST_LOAD_ACC,
    ST_EMIT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture endpoints, differences and step count
    logic div_init;   // load remainder with the selected magnitude, clear quotient
    logic div_sel_y;  // divider works on y
    logic div_step;   // one quotient bit
    logic store_x;    // signed quotient into the x increment
    logic store_y;    // signed quotient into the y increment
    logic inc_clear;  // zero-length line: x increment is zero
    logic acc_init;   // accumulators to the first endpoint, point count to zero
    logic emit;       // show one point, advance accumulators
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic steps_zero;
    logic last;
  } status_t;

endpackage

@@ src/dlpg_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlpg_ctrl
// sequencer: setup, 2 divisions on the shared divider if steps > 0, point walk
// ----------------------------------------------------------------------------
module dlpg_ctrl #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  dlpg_pkg::status_t status_i,
  output dlpg_pkg::cmd_t    cmd_o
);
  import dlpg_pkg::*;

  localparam int unsigned CNT_W = $clog2(FRAC_BITS + 1);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              div_last;

  assign div_last = (cnt_q == CNT_W'(FRAC_BITS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        if (status_i.steps_zero) begin
          cmd_o.inc_clear = 1'b1;
          state_d         = ST_LOAD_ACC;
        end else begin
          state_d = ST_DIV_X;
        end
      end
      ST_DIV_X: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (div_last) begin
          state_d = ST_LOAD_Y;
        end
      end
      ST_LOAD_Y: begin
        cmd_o.store_x   = 1'b1;
        cmd_o.div_init  = 1'b1;
        cmd_o.div_sel_y = 1'b1;
        cnt_d           = '0;
        state_d         = ST_DIV_Y;
      end
      ST_DIV_Y: begin
        cmd_o.div_step  = 1'b1;
        cmd_o.div_sel_y = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        if (div_last) begin
          state_d = ST_LOAD_ACC;
        end
      end
      ST_LOAD_ACC: begin
        cmd_o.store_y  = 1'b1;
        cmd_o.acc_init = 1'b1;
        state_d        = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        if (status_i.last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  a_accept_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (state_q == ST_PREP))
    else $error("accepted request did not enter setup");

  a_last_ends_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && status_i.last) |=> (state_q == ST_IDLE))
    else $error("walk did not end on the last point");

  a_div_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD_Y) |-> ($past(cnt_q) == CNT_W'(FRAC_BITS)))
    else $error("x division ended early");

endmodule

@@ src/dlpg_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlpg_datapath
// endpoint registers, restoring divider, increment and accumulator registers
// ----------------------------------------------------------------------------
module dlpg_datapath #(
  parameter int unsigned COORD_BITS = 6,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dlpg_pkg::cmd_t                      cmd_i,
  output dlpg_pkg::status_t                   status_o,
  input  logic signed [COORD_BITS-1:0]        x_start_i,
  input  logic signed [COORD_BITS-1:0]        y_start_i,
  input  logic signed [COORD_BITS-1:0]        x_end_i,
  input  logic signed [COORD_BITS-1:0]        y_end_i,
  output logic signed [dlpg_pkg::OUT_W-1:0]   point_x_o,
  output logic signed [dlpg_pkg::OUT_W-1:0]   point_y_o,
  output logic                                last_point_o,
  output logic                                point_valid_o
);
  import dlpg_pkg::*;

  localparam int unsigned CW  = COORD_BITS;
  localparam int unsigned DW  = CW + 1;              // difference / remainder
  localparam int unsigned QW  = FRAC_BITS + 1;       // quotient magnitude, up to 2^FRAC_BITS
  localparam int unsigned IW  = FRAC_BITS + 2;       // signed increment
  localparam int unsigned AW  = CW + FRAC_BITS + 1;  // accumulator
  localparam int unsigned EW  = AW + OUT_FRAC;
  localparam int unsigned SHR = (FRAC_BITS > OUT_FRAC) ? FRAC_BITS - OUT_FRAC : 0;
  localparam int unsigned SHL = (FRAC_BITS < OUT_FRAC) ? OUT_FRAC - FRAC_BITS : 0;

  logic signed [CW-1:0] xs_q, ys_q;
  logic [CW-1:0]        adx_q, ady_q, steps_q;
  logic                 xneg_q, yneg_q;

  logic signed [DW-1:0] dx, dy, mx, my;
  logic [CW-1:0]        adx_d, ady_d;

  logic [DW-1:0]        rem_q, rem_d, rem_sub;
  logic [QW-1:0]        quo_q, quo_d;
  logic                 quo_bit;

  logic signed [IW-1:0] quo_mag;
  logic signed [IW-1:0] xinc_q, yinc_q;
  logic signed [AW-1:0] accx_q, accy_q;
  logic [CW-1:0]        k_q;

  logic signed [EW-1:0] extx, exty, cvtx, cvty;

  logic signed [OUT_W-1:0] point_x_q, point_y_q;
  logic                    last_q, valid_q;

  // endpoint differences and magnitudes
  always_comb begin
    dx    = DW'(x_end_i) - DW'(x_start_i);
    dy    = DW'(y_end_i) - DW'(y_start_i);
    mx    = dx[DW-1] ? -dx : dx;
    my    = dy[DW-1] ? -dy : dy;
    adx_d = mx[CW-1:0];
    ady_d = my[CW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      xs_q    <= x_start_i;
      ys_q    <= y_start_i;
      adx_q   <= adx_d;
      ady_q   <= ady_d;
      xneg_q  <= dx[DW-1];
      yneg_q  <= dy[DW-1];
      steps_q <= (adx_d > ady_d) ? adx_d : ady_d;
    end
  end

  // restoring divider: |d| <= steps, so the quotient is 1 integer bit + fraction
  always_comb begin
    quo_bit = (rem_q >= {1'b0, steps_q});
    rem_sub = quo_bit ? rem_q - {1'b0, steps_q} : rem_q;
    rem_d   = {rem_sub[CW-1:0], 1'b0};
    quo_d   = {quo_q[QW-2:0], quo_bit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      quo_q <= '0;
    end else if (cmd_i.div_init) begin
      rem_q <= {1'b0, cmd_i.div_sel_y ? ady_q : adx_q};
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quo_mag = IW'({1'b0, quo_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.inc_clear) begin
      xinc_q <= '0;
    end else if (cmd_i.store_x) begin
      xinc_q <= xneg_q ? -quo_mag : quo_mag;
    end
    if (cmd_i.store_y) begin
      yinc_q <= yneg_q ? -quo_mag : quo_mag;
    end
  end

  // accumulators walk from the first endpoint
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_init) begin
      accx_q <= {xs_q[CW-1], xs_q, {FRAC_BITS{1'b0}}};
      accy_q <= {ys_q[CW-1], ys_q, {FRAC_BITS{1'b0}}};
      k_q    <= '0;
    end else if (cmd_i.emit) begin
      accx_q <= accx_q + {{(AW-IW){xinc_q[IW-1]}}, xinc_q};
      accy_q <= accy_q + {{(AW-IW){yinc_q[IW-1]}}, yinc_q};
      k_q    <= k_q + 1'b1;
    end
  end

  assign status_o.steps_zero = (steps_q == '0);
  assign status_o.last       = (k_q == steps_q);

  // to 8 fraction bits, arithmetic shift rounds toward minus infinity
  always_comb begin
    extx = {{OUT_FRAC{accx_q[AW-1]}}, accx_q};
    exty = {{OUT_FRAC{accy_q[AW-1]}}, accy_q};
    cvtx = (extx <<< SHL) >>> SHR;
    cvty = (exty <<< SHL) >>> SHR;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      point_x_q <= cvtx[OUT_W-1:0];
      point_y_q <= cvty[OUT_W-1:0];
      last_q    <= status_o.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
    end
  end

  assign point_x_o     = point_x_q;
  assign point_y_o     = point_y_q;
  assign last_point_o  = last_q;
  assign point_valid_o = valid_q;

  a_quotient_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (quo_q <= QW'(1 << FRAC_BITS)))
    else $error("quotient grew past one");

  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && last_q) |=> !valid_q)
    else $error("point emitted right after the last point");

endmodule

@@ src/dda_line_point_generator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_line_point_generator_top
// dda line walk: endpoints in, steps+1 fixed-point points out
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The block then
// runs a setup state, two divisions of FRAC_BITS+1 quotient bits each on one
// shared restoring divider with a load state after each, and then puts out
// steps+1 points, one per cycle, where steps = max(|dx|, |dy|). A zero-length
// line skips both divisions. Each point is valid for exactly one cycle while
// point_valid_o is high and cannot be held off, so the receiver must take
// every point as it comes. last_point_o marks the final one.
module dda_line_point_generator_top #(
  parameter int unsigned COORD_BITS = 6,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [COORD_BITS-1:0]       x_start_i,
  input  logic signed [COORD_BITS-1:0]       y_start_i,
  input  logic signed [COORD_BITS-1:0]       x_end_i,
  input  logic signed [COORD_BITS-1:0]       y_end_i,
  output logic signed [dlpg_pkg::OUT_W-1:0]  point_x_o,
  output logic signed [dlpg_pkg::OUT_W-1:0]  point_y_o,
  output logic                               last_point_o,
  output logic                               point_valid_o
);
  import dlpg_pkg::*;

  cmd_t    cmd;
  status_t status;

  dlpg_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .busy_o   (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  dlpg_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .x_start_i     (x_start_i),
    .y_start_i     (y_start_i),
    .x_end_i       (x_end_i),
    .y_end_i       (y_end_i),
    .point_x_o     (point_x_o),
    .point_y_o     (point_y_o),
    .last_point_o  (last_point_o),
    .point_valid_o (point_valid_o)
  );

endmodule

@@ tb/dlpg_line_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlpg_line_checker
// watches the line requests and the point stream, predicts every point of
// each accepted line and compares the stream against it field by field
// ----------------------------------------------------------------------------
module dlpg_line_checker #(
  parameter int unsigned COORD_BITS = 6,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              busy_i,
  input  logic signed [COORD_BITS-1:0]      x_start_i,
  input  logic signed [COORD_BITS-1:0]      y_start_i,
  input  logic signed [COORD_BITS-1:0]      x_end_i,
  input  logic signed [COORD_BITS-1:0]      y_end_i,
  input  logic signed [dlpg_pkg::OUT_W-1:0] point_x_i,
  input  logic signed [dlpg_pkg::OUT_W-1:0] point_y_i,
  input  logic                              last_point_i,
  input  logic                              point_valid_i,
  output int                                fail_count_o,
  output int                                pending_o
);

  typedef struct packed {
    logic signed [dlpg_pkg::OUT_W-1:0] x;
    logic signed [dlpg_pkg::OUT_W-1:0] y;
    logic                              last;
  } line_point_t;

  line_point_t line_points_q[$];

  // accumulator with FRAC_BITS fraction bits into the 8-fraction-bit output
  function automatic longint to_point_format(input longint acc);
    if (FRAC_BITS > dlpg_pkg::OUT_FRAC) begin
      return acc >>> (FRAC_BITS - dlpg_pkg::OUT_FRAC);
    end else begin
      return acc <<< (dlpg_pkg::OUT_FRAC - FRAC_BITS);
    end
  endfunction

  task automatic walk_line(input logic signed [COORD_BITS-1:0] xs_c,
                           input logic signed [COORD_BITS-1:0] ys_c,
                           input logic signed [COORD_BITS-1:0] xe_c,
                           input logic signed [COORD_BITS-1:0] ye_c);
    longint      xs, ys, dx, dy, adx, ady, steps, xinc, yinc, unit, k, px, py;
    line_point_t pt;
    xs    = xs_c;
    ys    = ys_c;
    dx    = longint'(xe_c) - xs;
    dy    = longint'(ye_c) - ys;
    adx   = (dx < 0) ? -dx : dx;
    ady   = (dy < 0) ? -dy : dy;
    steps = (adx > ady) ? adx : ady;
    unit  = longint'(1) << FRAC_BITS;
    xinc  = 0;
    yinc  = 0;
    // zero-length line: no division, a single point
    if (steps > 0) begin
      xinc = (dx * unit) / steps;
      yinc = (dy * unit) / steps;
    end
    for (k = 0; k <= steps; k++) begin
      px      = to_point_format(xs * unit + k * xinc);
      py      = to_point_format(ys * unit + k * yinc);
      pt.x    = px[dlpg_pkg::OUT_W-1:0];
      pt.y    = py[dlpg_pkg::OUT_W-1:0];
      pt.last = (k == steps);
      line_points_q.insert(line_points_q.size(), pt);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    line_point_t exp_pt;
    if (!rst_ni) begin
      line_points_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // points leaving now belong to older requests, so compare first
      if (point_valid_i) begin
        if (line_points_q.size() == 0) begin
          $error("unexpected point x=%0d y=%0d last=%0b",
                 point_x_i, point_y_i, last_point_i);
          fail_count_o++;
        end else begin
          exp_pt = line_points_q.pop_front();
          if (point_x_i !== exp_pt.x) begin
            $error("point_x mismatch: expected %0d, got %0d", exp_pt.x, point_x_i);
            fail_count_o++;
          end
          if (point_y_i !== exp_pt.y) begin
            $error("point_y mismatch: expected %0d, got %0d", exp_pt.y, point_y_i);
            fail_count_o++;
          end
          if (last_point_i !== exp_pt.last) begin
            $error("last_point mismatch: expected %0b, got %0b", exp_pt.last, last_point_i);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i) begin
        walk_line(x_start_i, y_start_i, x_end_i, y_end_i);
      end
      pending_o = line_points_q.size();
    end
  end

endmodule

@@ tb/dda_line_point_generator_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_line_point_generator_top_test
// drives directed, then random line requests in bursts into the dda point
// generator; a checker beside the block predicts and compares every point
// ----------------------------------------------------------------------------
module dda_line_point_generator_top_test;

  localparam int unsigned COORD_BITS = 6;
  localparam int unsigned FRAC_BITS  = 8;
  localparam int          NUM_RANDOM = 360;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              start;
  logic                              busy;
  logic signed [COORD_BITS-1:0]      x_start, y_start, x_end, y_end;
  logic signed [dlpg_pkg::OUT_W-1:0] point_x, point_y;
  logic                              last_point, point_valid;
  int                                fail_count, pending_points;

  dda_line_point_generator_top #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .x_start_i    (x_start),
    .y_start_i    (y_start),
    .x_end_i      (x_end),
    .y_end_i      (y_end),
    .point_x_o    (point_x),
    .point_y_o    (point_y),
    .last_point_o (last_point),
    .point_valid_o(point_valid)
  );

  dlpg_line_checker #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .x_start_i    (x_start),
    .y_start_i    (y_start),
    .x_end_i      (x_end),
    .y_end_i      (y_end),
    .point_x_i    (point_x),
    .point_y_i    (point_y),
    .last_point_i (last_point),
    .point_valid_i(point_valid),
    .fail_count_o (fail_count),
    .pending_o    (pending_points)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_line(input logic signed [COORD_BITS-1:0] xs,
                           input logic signed [COORD_BITS-1:0] ys,
                           input logic signed [COORD_BITS-1:0] xe,
                           input logic signed [COORD_BITS-1:0] ye);
    start   <= 1'b1;
    x_start <= xs;
    y_start <= ys;
    x_end   <= xe;
    y_end   <= ye;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  // n must be at least one so start is never lowered and raised in one step
  task automatic idle_cycles(input int n);
    start   <= 1'b0;
    x_start <= COORD_BITS'($urandom_range(0, 63));
    y_start <= COORD_BITS'($urandom_range(0, 63));
    x_end   <= COORD_BITS'($urandom_range(0, 63));
    y_end   <= COORD_BITS'($urandom_range(0, 63));
    repeat (n) @(negedge clk_i);
  endtask

  task automatic wait_points_drained();
    start <= 1'b0;
    do @(negedge clk_i); while (pending_points != 0);
  endtask

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int                           burst_left;
    int                           kind;
    logic signed [COORD_BITS-1:0] xs, ys, xe, ye;
    clk_i   = 1'b0;
    rst_ni  = 1'b0;
    start   = 1'b0;
    x_start = '0;
    y_start = '0;
    x_end   = '0;
    y_end   = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(negedge clk_i);

    // zero-length lines, corners, axes, single steps, inexact increments
    send_line(0, 0, 0, 0);
    send_line(-32, -32, -32, -32);
    send_line(31, 31, 31, 31);
    send_line(-32, -32, 31, 31);
    send_line(31, 31, -32, -32);
    send_line(-32, 31, 31, -32);
    send_line(31, -32, -32, 31);
    send_line(-32, 0, 31, 0);
    send_line(0, -32, 0, 31);
    send_line(0, 0, 1, 0);
    send_line(0, 0, 0, -1);
    send_line(0, 0, 3, 1);
    send_line(0, 0, -3, 1);
    send_line(5, -7, -20, 9);
    send_line(-32, -32, 31, -31);
    send_line(0, 0, -1, -32);
    send_line(-1, -1, -32, 31);
    send_line(31, 0, -32, 1);
    wait_points_drained();

    burst_left = 0;
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 10);
        if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 30));
      end
      burst_left--;
      if (i == NUM_RANDOM / 3 || i == 2 * NUM_RANDOM / 3) wait_points_drained();
      kind = $urandom_range(0, 9);
      xs   = COORD_BITS'($urandom_range(0, 63));
      ys   = COORD_BITS'($urandom_range(0, 63));
      if (kind < 6) begin
        xe = COORD_BITS'($urandom_range(0, 63));
        ye = COORD_BITS'($urandom_range(0, 63));
      end else if (kind < 9) begin
        // short lines, wrapping at the range ends is fine
        xe = COORD_BITS'(xs + $signed($urandom_range(0, 8)) - 4);
        ye = COORD_BITS'(ys + $signed($urandom_range(0, 8)) - 4);
      end else begin
        xe = xs;
        ye = ys;
      end
      send_line(xs, ys, xe, ye);
    end

    start <= 1'b0;
    while (pending_points != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
